// ===== rtl/fdc_pkg.sv =====
`timescale 1ns / 1ps

package fdc_pkg;

  // frame layouts
  localparam logic [1:0] FMT_PLAIN  = 2'd0;
  localparam logic [1:0] FMT_SERIAL = 2'd1;
  localparam logic [1:0] FMT_RADIO  = 2'd2;

  // verdict codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SHORT  = 3'd1;
  localparam logic [2:0] ST_MAGIC  = 3'd2;
  localparam logic [2:0] ST_CRC    = 3'd3;
  localparam logic [2:0] ST_MSG_ID = 3'd4;
  localparam logic [2:0] ST_LENGTH = 3'd5;

  // register map
  localparam logic [2:0] REG_FORMAT       = 3'd0;
  localparam logic [2:0] REG_SERIAL_MAGIC = 3'd1;
  localparam logic [2:0] REG_RADIO_MAGIC  = 3'd2;
  localparam logic [2:0] REG_MSG_ID_LIMIT = 3'd3;
  localparam logic [2:0] REG_MAX_PAYLOAD  = 3'd4;

  localparam logic [8:0]  POS_MAX  = 9'd511;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic       kind;
    logic       last_of_run;
    logic [7:0] payload_length;
    logic [7:0] message_id;
    logic [7:0] destination_id;
    logic [7:0] source_id;
    logic [7:0] sequence_number;
    logic [2:0] status;
    logic [7:0] payload_byte;
  } fdc_result_t;

  // one byte of CRC-16/MCRF4XX (reflected 0x8408), nibble-shift form
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic [7:0]  l;
    logic [7:0]  t;
    c = crc ^ {8'h00, b};
    l = c[7:0] ^ {c[3:0], 4'h0};
    t = {l[4:0], l[7:5]};
    l = l ^ (t & 8'h07);
    t = (t & 8'hF8) ^ ({t[6:0], t[7]} & 8'h0F) ^ c[15:8];
    return {l, t};
  endfunction

endpackage

// ===== rtl/fdc_result_fifo.sv =====
`timescale 1ns / 1ps

module fdc_result_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         wr_cnt,
  input  fdc_pkg::fdc_result_t wr_data0,
  input  fdc_pkg::fdc_result_t wr_data1,
  output logic               room_for_two,
  output logic               rd_valid,
  input  logic               rd_ready,
  output fdc_pkg::fdc_result_t rd_data
);
  import fdc_pkg::*;

  fdc_result_t mem [4];
  logic [1:0]  wptr;
  logic [1:0]  rptr;
  logic [2:0]  count;
  logic        pop;

  assign rd_valid     = (count != 3'd0);
  assign rd_data      = mem[rptr];
  assign pop          = rd_valid && rd_ready;
  assign room_for_two = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[wptr] <= wr_data0;
    end
    if (wr_cnt == 2'd2) begin
      mem[wptr + 2'd1] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + wr_cnt;
      rptr  <= rptr + {1'b0, pop};
      count <= count + {1'b0, wr_cnt} - {2'b00, pop};
    end
  end

endmodule

// ===== rtl/frame_deframer_crc16_checker_core.sv =====
`timescale 1ns / 1ps

// Byte-serial frame deframer with CRC-16/MCRF4XX check.
// Input stream s_*: one frame byte per beat, s_tlast on the final byte of the frame.
// Output stream m_*: m_tuser = 0 for a provisional payload byte, 1 for the frame verdict.
//   The verdict carries status and the captured header fields; m_tlast marks the final
//   beat caused by one input byte.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle, no read-back;
//   change registers only between frames with the output drained.
// Result path: a result beat is registered in the result queue when its input beat is accepted, then read onto m_*.
// Throughput: one input byte per cycle while s_tready is high. A final byte that is also
//   payload yields two beats, both written together into a four-entry result queue;
//   s_tready stays high while the queue has room for two beats.
// CRC runs two bytes behind the input so that at the final byte it covers everything but
//   the little-endian trailer, one table-free byte update per cycle while bytes are accepted.
// Reset (rst, synchronous): frame state clears, registers return to radio format, zero
//   magics, id limit 255, max payload 255; the result queue empties.
// Stall: while m_tready is low beats wait in the queue; once it is nearly full s_tready
//   drops, so nothing is lost or duplicated.
module frame_deframer_crc16_checker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tlast,   // end_of_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [fdc_pkg::OUT_DATA_W-1:0] m_tdata,  // [7:0] payload_byte, [10:8] status,
                                                   // [18:11] sequence_number,
                                                   // [26:19] source_id,
                                                   // [34:27] destination_id,
                                                   // [42:35] message_id,
                                                   // [50:43] payload_length, rest zero
  output logic        m_tlast,   // last_of_run
  output logic        m_tuser,   // kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import fdc_pkg::*;

  // configuration
  logic [1:0] frame_format;
  logic [7:0] serial_magic;
  logic [7:0] radio_magic;
  logic [7:0] message_id_limit;
  logic [7:0] max_payload;

  // frame state
  logic [8:0]  byte_position;
  logic [15:0] running_crc;
  logic [7:0]  trail0;
  logic [7:0]  trail1;
  logic [7:0]  held_sequence;
  logic [7:0]  held_source;
  logic [7:0]  held_destination;
  logic [7:0]  held_message_id;
  logic [7:0]  held_length;
  logic        magic_mismatch;

  logic [8:0]  byte_position_next;
  logic [15:0] running_crc_next;
  logic [7:0]  held_sequence_next;
  logic [7:0]  held_source_next;
  logic [7:0]  held_destination_next;
  logic [7:0]  held_message_id_next;
  logic [7:0]  held_length_next;
  logic        magic_mismatch_next;

  logic        accept;
  logic        room_for_two;
  logic [1:0]  fmt;
  logic [8:0]  hdr_len;
  logic [8:0]  min_len;
  logic [8:0]  body_pos;
  logic        is_payload;
  logic [2:0]  status;
  logic [1:0]  wr_cnt;
  fdc_result_t pay_res;
  fdc_result_t ver_res;
  fdc_result_t wr_data0;
  fdc_result_t rd_data;

  assign s_tready = room_for_two;
  assign accept   = s_tvalid && s_tready;
  assign fmt      = (frame_format == 2'd3) ? FMT_RADIO : frame_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_format     <= FMT_RADIO;
      serial_magic     <= '0;
      radio_magic      <= '0;
      message_id_limit <= 8'hFF;
      max_payload      <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FORMAT:       frame_format     <= cfg_data[1:0];
        REG_SERIAL_MAGIC: serial_magic     <= cfg_data;
        REG_RADIO_MAGIC:  radio_magic      <= cfg_data;
        REG_MSG_ID_LIMIT: message_id_limit <= cfg_data;
        REG_MAX_PAYLOAD:  max_payload      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (fmt)
      FMT_PLAIN:  begin hdr_len = 9'd2; min_len = 9'd2; end
      FMT_SERIAL: begin hdr_len = 9'd3; min_len = 9'd5; end
      default:    begin hdr_len = 9'd6; min_len = 9'd8; end
    endcase
  end

  // header capture and state update for the byte on s_tdata
  always_comb begin
    held_sequence_next    = held_sequence;
    held_source_next      = held_source;
    held_destination_next = held_destination;
    held_message_id_next  = held_message_id;
    held_length_next      = held_length;
    magic_mismatch_next   = magic_mismatch;

    if (byte_position == 9'd0) begin
      magic_mismatch_next = ((fmt == FMT_SERIAL) && (s_tdata != serial_magic)) ||
                            ((fmt == FMT_RADIO) && (s_tdata != radio_magic));
    end

    case (fmt)
      FMT_PLAIN: begin
        if (byte_position == 9'd0) held_message_id_next = s_tdata;
        else if (byte_position == 9'd1) held_length_next = s_tdata;
      end
      FMT_SERIAL: begin
        if (byte_position == 9'd1) held_message_id_next = s_tdata;
        else if (byte_position == 9'd2) held_length_next = s_tdata;
      end
      default: begin
        if (byte_position == 9'd1) held_sequence_next = s_tdata;
        else if (byte_position == 9'd2) held_source_next = s_tdata;
        else if (byte_position == 9'd3) held_destination_next = s_tdata;
        else if (byte_position == 9'd4) held_message_id_next = s_tdata;
        else if (byte_position == 9'd5) held_length_next = s_tdata;
      end
    endcase

    running_crc_next   = (byte_position >= 9'd2) ? crc_feed(running_crc, trail0) : running_crc;
    byte_position_next = (byte_position == POS_MAX) ? POS_MAX : byte_position + 9'd1;
  end

  assign body_pos   = byte_position - hdr_len;
  assign is_payload = (byte_position >= hdr_len) && (body_pos < {1'b0, held_length_next});

  // checks in priority order; byte_position_next is the frame byte count
  always_comb begin
    if (byte_position_next < min_len) begin
      status = ST_SHORT;
    end else if ((fmt != FMT_PLAIN) && magic_mismatch_next) begin
      status = ST_MAGIC;
    end else if ((fmt != FMT_PLAIN) && (running_crc_next != {s_tdata, trail1})) begin
      status = ST_CRC;
    end else if (held_message_id_next >= message_id_limit) begin
      status = ST_MSG_ID;
    end else if (({1'b0, held_length_next} != byte_position_next - min_len) ||
                 (held_length_next > max_payload)) begin
      status = ST_LENGTH;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    pay_res              = '0;
    pay_res.payload_byte = s_tdata;
    pay_res.last_of_run  = !s_tlast;

    ver_res                 = '0;
    ver_res.kind            = 1'b1;
    ver_res.last_of_run     = 1'b1;
    ver_res.status          = status;
    ver_res.sequence_number = held_sequence_next;
    ver_res.source_id       = held_source_next;
    ver_res.destination_id  = held_destination_next;
    ver_res.message_id      = held_message_id_next;
    ver_res.payload_length  = held_length_next;

    wr_data0 = is_payload ? pay_res : ver_res;
    if (!accept) begin
      wr_cnt = 2'd0;
    end else begin
      wr_cnt = {1'b0, is_payload} + {1'b0, s_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      byte_position    <= '0;
      running_crc      <= CRC_INIT;
      trail0           <= '0;
      trail1           <= '0;
      held_sequence    <= '0;
      held_source      <= '0;
      held_destination <= '0;
      held_message_id  <= '0;
      held_length      <= '0;
      magic_mismatch   <= 1'b0;
    end else if (accept) begin
      byte_position    <= byte_position_next;
      running_crc      <= running_crc_next;
      trail0           <= trail1;
      trail1           <= s_tdata;
      held_sequence    <= held_sequence_next;
      held_source      <= held_source_next;
      held_destination <= held_destination_next;
      held_message_id  <= held_message_id_next;
      held_length      <= held_length_next;
      magic_mismatch   <= magic_mismatch_next;
    end
  end

  fdc_result_fifo u_results (
    .clk          (clk),
    .rst          (rst),
    .wr_cnt       (wr_cnt),
    .wr_data0     (wr_data0),
    .wr_data1     (ver_res),
    .room_for_two (room_for_two),
    .rd_valid     (m_tvalid),
    .rd_ready     (m_tready),
    .rd_data      (rd_data)
  );

  assign m_tdata = {5'b00000, rd_data.payload_length, rd_data.message_id,
                    rd_data.destination_id, rd_data.source_id, rd_data.sequence_number,
                    rd_data.status, rd_data.payload_byte};
  assign m_tlast = rd_data.last_of_run;
  assign m_tuser = rd_data.kind;

endmodule

// ===== rtl/fdc_checker.sv =====
`timescale 1ns / 1ps

module fdc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fdc_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                          m_tlast,
  input logic                          m_tuser
);
  import fdc_pkg::*;

  // queue comes up empty
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a verdict always closes the run of its byte
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("verdict beat without tlast");

  a_verdict_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[7:0] == 8'h00) && (m_tdata[10:8] <= ST_LENGTH))
    else $error("verdict carries payload byte or bad status");

  a_payload_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[OUT_DATA_W-1:8] == '0))
    else $error("payload beat carries header fields");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

endmodule

bind frame_deframer_crc16_checker_core fdc_checker u_fdc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
